// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define FTD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, gated by reset.
`define FTD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/ftd_pkg.sv =====
package ftd_pkg;

   // Field and register widths.
   localparam int SAMPLE_WIDTH        = 8;
   localparam int CHANNEL_WIDTH       = 12;
   localparam int CHANNEL_COUNT_WIDTH = 13;
   localparam int FACTOR_WIDTH        = 9;
   localparam int FRAME_WIDTH         = 8;
   localparam int SUM_WIDTH           = 16;
   localparam int CSR_DATA_WIDTH      = 13;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int DIV_COUNT_WIDTH     = 3;

   // Limits on the configuration registers.
   localparam int MAX_CHANNELS   = 4096;
   localparam int MAX_DECIMATION = 256;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHANNEL_COUNT     = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DECIMATION_FACTOR = 1'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CALC = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } ftd_state_type;

endpackage

// ===== rtl/ftd_req_if.sv =====
interface ftd_req_if;
   import ftd_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample;
   logic                    end_of_stream;

   modport source (output valid, output sample, output end_of_stream, input ready);
   modport sink   (input valid, input sample, input end_of_stream, output ready);
endinterface

// ===== rtl/ftd_rsp_if.sv =====
interface ftd_rsp_if;
   import ftd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [SAMPLE_WIDTH-1:0]  average;
   logic [CHANNEL_WIDTH-1:0] channel;
   logic                     frame_done;

   modport source (output valid, output average, output channel, output frame_done,
                   input ready);
   modport sink   (input valid, input average, input channel, input frame_done,
                   output ready);
endinterface

// ===== rtl/filterbank_time_decimator_top.sv =====
// Boxcar time decimator for an 8-bit filterbank stream, channel-fastest within each
// frame. One 16-bit running sum per channel lives in a synchronous memory of 4096
// entries and is read, updated and written back once per sample; on the last frame
// of a group the completed sum is divided by the decimation factor, clamped to 255
// and sent out with its channel number and a last-channel flag. A sample that does
// not close a group passes a memory read, then an add and write-back; a sample on
// the last frame of a group then also runs the restoring divider, which produces
// one quotient bit per cycle, and waits in its done state until the output
// register is free. The output register lets the next sample enter while a
// result still waits. An end-of-stream sample is processed normally and then
// restarts the channel and frame counters, dropping any partial group. The memory
// needs no clearing after reset: the first frame of each group overwrites its sums.
`include "assert_macros.svh"

module filterbank_time_decimator_top (
   input  logic                                  clock,
   input  logic                                  reset,
   ftd_req_if.sink                               req_chan,
   ftd_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [ftd_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ftd_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import ftd_pkg::*;

   // Configuration registers.
   logic [CHANNEL_COUNT_WIDTH-1:0] channel_count_ff, channel_count_in;
   logic [FACTOR_WIDTH-1:0]        factor_ff, factor_in;

   // Sequencer and counters.
   ftd_state_type                  state_ff, state_in;
   logic [CHANNEL_WIDTH-1:0]       channel_position_ff, channel_position_in;
   logic [FRAME_WIDTH-1:0]         frame_in_group_ff, frame_in_group_in;

   // Accepted transaction and memory read data.
   logic [SAMPLE_WIDTH-1:0]        sample_ff;
   logic                           eos_ff;
   logic [SUM_WIDTH-1:0]           rd_data_ff;
   logic [SUM_WIDTH-1:0]           sums_mem [MAX_CHANNELS];

   // Divider state.
   logic [FACTOR_WIDTH-1:0]        div_rem_ff, div_rem_in;
   logic [SAMPLE_WIDTH-1:0]        div_low_ff, div_low_in;
   logic [DIV_COUNT_WIDTH-1:0]     div_cnt_ff, div_cnt_in;
   logic                           clamp_ff, clamp_in;
   logic [CHANNEL_WIDTH-1:0]       pend_channel_ff, pend_channel_in;
   logic                           pend_last_ff, pend_last_in;

   // Output register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0]        rsp_average_ff, rsp_average_in;
   logic [CHANNEL_WIDTH-1:0]       rsp_channel_ff, rsp_channel_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic                           req_fire;
   logic                           rsp_fire;
   logic [CHANNEL_COUNT_WIDTH-1:0] nch_m1;
   logic [FACTOR_WIDTH-1:0]        fac_eff;
   logic [FACTOR_WIDTH-1:0]        fac_m1;
   logic                           last_chan;
   logic                           last_frame;
   logic [SUM_WIDTH-1:0]           new_sum;
   logic                           mem_we;
   logic [FACTOR_WIDTH:0]          div_trial;
   logic                           div_qbit;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.average    = rsp_average_ff;
   assign rsp_chan.channel    = rsp_channel_ff;
   assign rsp_chan.frame_done = rsp_last_ff;

   // Effective register values: zero counts as one, large values saturate.
   always_comb begin
      if (channel_count_ff == '0) begin
         nch_m1 = '0;
      end else if (channel_count_ff > CHANNEL_COUNT_WIDTH'(MAX_CHANNELS)) begin
         nch_m1 = CHANNEL_COUNT_WIDTH'(MAX_CHANNELS - 1);
      end else begin
         nch_m1 = channel_count_ff - CHANNEL_COUNT_WIDTH'(1);
      end
      if (factor_ff == '0) begin
         fac_eff = FACTOR_WIDTH'(1);
      end else if (factor_ff > FACTOR_WIDTH'(MAX_DECIMATION)) begin
         fac_eff = FACTOR_WIDTH'(MAX_DECIMATION);
      end else begin
         fac_eff = factor_ff;
      end
      fac_m1 = fac_eff - FACTOR_WIDTH'(1);
   end

   // Group position of the sample in flight.
   assign last_chan  = {1'b0, channel_position_ff} >= nch_m1;
   assign last_frame = {1'b0, frame_in_group_ff} >= fac_m1;

   // The first frame of a group overwrites the stored sum.
   assign new_sum = (frame_in_group_ff == '0) ? SUM_WIDTH'(sample_ff)
                                              : rd_data_ff + SUM_WIDTH'(sample_ff);
   assign mem_we  = (state_ff == ST_CALC);

   // One restoring division step: bring down the next dividend bit.
   assign div_trial = {div_rem_ff, div_low_ff[SAMPLE_WIDTH-1]};
   assign div_qbit  = div_trial >= {1'b0, fac_eff};

   // Sum memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sums_mem[channel_position_ff] <= new_sum;
      end
      if (req_fire) begin
         rd_data_ff <= sums_mem[channel_position_ff];
      end
   end

   // Configuration writes.
   always_comb begin
      channel_count_in = channel_count_ff;
      factor_in        = factor_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_write_data;
            end
            CSR_DECIMATION_FACTOR: begin
               factor_in = csr_write_data[FACTOR_WIDTH-1:0];
            end
            default: begin
               channel_count_in = channel_count_ff;
            end
         endcase
      end
   end

   // Sequencer, counters, divider and output register.
   always_comb begin
      state_in            = state_ff;
      channel_position_in = channel_position_ff;
      frame_in_group_in   = frame_in_group_ff;
      div_rem_in          = div_rem_ff;
      div_low_in          = div_low_ff;
      div_cnt_in          = div_cnt_ff;
      clamp_in            = clamp_ff;
      pend_channel_in     = pend_channel_ff;
      pend_last_in        = pend_last_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_fire;
      rsp_average_in      = rsp_average_ff;
      rsp_channel_in      = rsp_channel_ff;
      rsp_last_in         = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            // Advance the counters as the sum is written back.
            if (last_chan) begin
               channel_position_in = '0;
               frame_in_group_in   = last_frame ? '0 : frame_in_group_ff + FRAME_WIDTH'(1);
            end else begin
               channel_position_in = channel_position_ff + CHANNEL_WIDTH'(1);
            end
            if (eos_ff) begin
               channel_position_in = '0;
               frame_in_group_in   = '0;
            end
            // A completed group starts the divider.
            pend_channel_in = channel_position_ff;
            pend_last_in    = last_chan;
            clamp_in        = {1'b0, new_sum} >= {fac_eff, SAMPLE_WIDTH'(0)};
            div_rem_in      = FACTOR_WIDTH'(new_sum[SUM_WIDTH-1:SAMPLE_WIDTH]);
            div_low_in      = new_sum[SAMPLE_WIDTH-1:0];
            div_cnt_in      = '1;
            state_in        = last_frame ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            div_rem_in = div_qbit ? FACTOR_WIDTH'(div_trial - {1'b0, fac_eff})
                                  : div_trial[FACTOR_WIDTH-1:0];
            div_low_in = {div_low_ff[SAMPLE_WIDTH-2:0], div_qbit};
            div_cnt_in = div_cnt_ff - DIV_COUNT_WIDTH'(1);
            if (div_cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = clamp_ff ? '1 : div_low_ff;
               rsp_channel_in = pend_channel_ff;
               rsp_last_in    = pend_last_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff    <= CHANNEL_COUNT_WIDTH'(1);
         factor_ff           <= FACTOR_WIDTH'(1);
         state_ff            <= ST_IDLE;
         channel_position_ff <= '0;
         frame_in_group_ff   <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         channel_count_ff    <= channel_count_in;
         factor_ff           <= factor_in;
         state_ff            <= state_in;
         channel_position_ff <= channel_position_in;
         frame_in_group_ff   <= frame_in_group_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_chan.sample;
         eos_ff    <= req_chan.end_of_stream;
      end
      div_rem_ff      <= div_rem_in;
      div_low_ff      <= div_low_in;
      div_cnt_ff      <= div_cnt_in;
      clamp_ff        <= clamp_in;
      pend_channel_ff <= pend_channel_in;
      pend_last_ff    <= pend_last_in;
      rsp_average_ff  <= rsp_average_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_last_ff     <= rsp_last_in;
   end

   // The state register always holds exactly one code.
   `FTD_ASSERT_NOW(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff))
   // The divider runs its full count before handing over a quotient.
   `FTD_ASSERT_NEXT(a_div_runs, clock, reset, (state_ff == ST_DIV) && (div_cnt_ff != '0), state_ff == ST_DIV)
   // A sample that does not close a group never raises a result.
   `FTD_ASSERT_NEXT(a_no_early_rsp, clock, reset, (state_ff == ST_CALC) && !last_frame, !$rose(rsp_valid_ff))
   // End of stream restarts both counters.
   `FTD_ASSERT_NEXT(a_eos_restart, clock, reset, (state_ff == ST_CALC) && eos_ff, (channel_position_ff == '0) && (frame_in_group_ff == '0))

endmodule
